FILE: rtl/vtrs_pkg.sv
// Types and constants shared by the virtual throttle and engine speed block.
package vtrs_pkg;

    localparam int THR_FRAC_BITS = 16;
    localparam int THR_W         = THR_FRAC_BITS + 1;
    localparam int RPM_W         = 22;
    localparam int STEP_W        = 16;
    localparam int CFG_DATA_W    = 22;
    localparam int CFG_IDX_W     = 3;

    localparam logic [THR_W-1:0] THR_ONE = THR_W'(1) << THR_FRAC_BITS;
    localparam logic [RPM_W-1:0] RPM_MAX = '1;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_STARTING = 2'd1,
        MODE_RUNNING  = 2'd2
    } t_engine_mode;

    localparam logic [1:0] MOTION_ACCEL = 2'd1;
    localparam logic [1:0] MOTION_DECEL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RPM_IDLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_ACCEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_DECEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEADY_DECAY = 3'd6;

    typedef struct packed {
        logic       throttle_due;
        logic [1:0] motion_class;
        logic       start_done;
        logic       restart;
        logic       off_request;
    } t_tick_item;

    typedef struct packed {
        logic [1:0]       engine_state;
        logic [RPM_W-1:0] rpm;
        logic [THR_W-1:0] throttle;
        logic             start_sound;
        logic             sound_off;
        logic             audio_update;
    } t_result_item;

endpackage

FILE: rtl/virtual_throttle_rpm_slew_unit.sv
// Virtual throttle and engine speed slew unit: top level.
//
// One tick item per clock cycle sustained unless the output stalls: a tick is
// held in an input register, and the throttle update, the engine state step
// and the speed slew all happen in the cycle that moves it into the result
// register. That loop through the throttle update, the target multiply and
// the speed clamp sets the rate. The input stage stalls only while a result
// waits and the output side holds ready low.
// Configuration writes take effect at once and belong to idle periods.
module virtual_throttle_rpm_slew_unit
    import vtrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_tick_item            i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_result_item          o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [RPM_W-1:0]  r_rpm_idle, r_rpm_max;
    logic [STEP_W-1:0] r_rpm_accel, r_rpm_decel;
    logic [THR_W-1:0]  r_ramp_up, r_ramp_down, r_steady_decay;

    // pipeline
    logic         r_in_valid;
    t_tick_item   r_in_item;
    logic         r_out_valid;
    t_result_item r_out_item;

    // engine state
    t_engine_mode     r_mode, n_mode;
    logic [THR_W-1:0] r_thr, n_thr;
    logic [RPM_W-1:0] r_speed, n_speed;

    logic w_out_free, w_fire;
    logic w_start_sound, w_sound_off, w_audio;

    // throttle update
    logic [THR_W:0]   w_thr_sum;
    logic [THR_W-1:0] w_thr_up, w_thr_dn, w_thr_decay, w_thr_cls, w_thr_upd;

    // speed slew
    logic [RPM_W-1:0]         w_span;
    logic [THR_W+RPM_W-1:0]   w_tprod;
    logic [RPM_W:0]           w_target_raw;
    logic [RPM_W-1:0]         w_target;
    logic [STEP_W+1:0]        w_acc3;
    logic [STEP_W+THR_W+1:0]  w_sprod;
    logic [STEP_W+2:0]        w_step;
    logic [RPM_W:0]           w_rise;
    logic [RPM_W-1:0]         w_fall, w_slew;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || w_out_free;
    assign w_fire      = r_in_valid && w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_idle     <= RPM_W'(204800);
            r_rpm_max      <= RPM_W'(2048000);
            r_rpm_accel    <= STEP_W'(12800);
            r_rpm_decel    <= STEP_W'(7680);
            r_ramp_up      <= THR_W'(1638);
            r_ramp_down    <= THR_W'(983);
            r_steady_decay <= THR_W'(328);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RPM_IDLE:     r_rpm_idle     <= i_cfg_data[RPM_W-1:0];
                CFG_RPM_MAX:      r_rpm_max      <= i_cfg_data[RPM_W-1:0];
                CFG_RPM_ACCEL:    r_rpm_accel    <= i_cfg_data[STEP_W-1:0];
                CFG_RPM_DECEL:    r_rpm_decel    <= i_cfg_data[STEP_W-1:0];
                CFG_RAMP_UP:      r_ramp_up      <= i_cfg_data[THR_W-1:0];
                CFG_RAMP_DOWN:    r_ramp_down    <= i_cfg_data[THR_W-1:0];
                CFG_STEADY_DECAY: r_steady_decay <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // throttle update, only while running and a motion sample is due
    always_comb begin
        w_thr_sum   = (THR_W+1)'(r_thr) + (THR_W+1)'(r_ramp_up);
        w_thr_up    = (w_thr_sum > (THR_W+1)'(THR_ONE)) ? THR_ONE : w_thr_sum[THR_W-1:0];
        w_thr_dn    = (r_thr > r_ramp_down) ? r_thr - r_ramp_down : '0;
        w_thr_decay = (r_thr > r_steady_decay) ? r_thr - r_steady_decay : '0;
        if (r_in_item.motion_class == MOTION_ACCEL) begin
            w_thr_cls = w_thr_up;
        end else if (r_in_item.motion_class == MOTION_DECEL) begin
            w_thr_cls = w_thr_dn;
        end else begin
            w_thr_cls = w_thr_decay;
        end
        w_thr_upd = (r_in_item.throttle_due && r_mode == MODE_RUNNING) ? w_thr_cls : r_thr;
    end

    // target and step from the updated throttle; never overshoot the target
    always_comb begin
        w_span       = (r_rpm_max > r_rpm_idle) ? r_rpm_max - r_rpm_idle : '0;
        w_tprod      = (THR_W+RPM_W)'(w_thr_upd) * (THR_W+RPM_W)'(w_span);
        w_target_raw = (RPM_W+1)'(r_rpm_idle)
                     + (RPM_W+1)'(w_tprod[THR_W+RPM_W-1:THR_FRAC_BITS]);
        w_target     = w_target_raw[RPM_W] ? RPM_MAX : w_target_raw[RPM_W-1:0];
        w_acc3       = (STEP_W+2)'({r_rpm_accel, 1'b0}) + (STEP_W+2)'(r_rpm_accel);
        w_sprod      = (STEP_W+THR_W+2)'(w_acc3) * (STEP_W+THR_W+2)'(w_thr_upd);
        w_step       = (STEP_W+3)'(r_rpm_accel)
                     + (STEP_W+3)'(w_sprod[STEP_W+THR_W+1:THR_FRAC_BITS+1]);
        w_rise       = (RPM_W+1)'(r_speed) + (RPM_W+1)'(w_step);
        w_fall       = (r_speed > RPM_W'(r_rpm_decel)) ? r_speed - RPM_W'(r_rpm_decel) : '0;
        if (r_speed < w_target) begin
            w_slew = (w_rise > (RPM_W+1)'(w_target)) ? w_target : w_rise[RPM_W-1:0];
        end else begin
            w_slew = (w_fall < w_target) ? w_target : w_fall;
        end
    end

    // next engine mode; restart is applied before off, off wins
    always_comb begin
        t_engine_mode w_mode_req;
        w_mode_req = r_mode;
        if (r_in_item.restart) w_mode_req = MODE_STARTING;
        if (r_in_item.off_request) w_mode_req = MODE_OFF;
        unique case (w_mode_req)
            MODE_STARTING: n_mode = r_in_item.start_done ? MODE_RUNNING : MODE_STARTING;
            MODE_RUNNING:  n_mode = MODE_RUNNING;
            default:       n_mode = MODE_STARTING;
        endcase
    end

    // datapath and pulses per mode
    always_comb begin
        t_engine_mode w_mode_req;
        logic [THR_W-1:0] w_thr_rs;
        logic [RPM_W-1:0] w_speed_rs;
        w_mode_req    = r_mode;
        w_thr_rs      = w_thr_upd;
        w_speed_rs    = r_speed;
        w_start_sound = 1'b0;
        w_sound_off   = 1'b0;
        w_audio       = 1'b0;
        if (r_in_item.restart) begin
            w_mode_req    = MODE_STARTING;
            w_thr_rs      = '0;
            w_speed_rs    = '0;
            w_start_sound = 1'b1;
        end
        if (r_in_item.off_request) w_mode_req = MODE_OFF;
        n_thr   = w_thr_rs;
        n_speed = w_speed_rs;
        unique case (w_mode_req)
            MODE_STARTING: begin
                if (r_in_item.start_done) begin
                    n_speed = r_rpm_idle;
                    w_audio = 1'b1;
                end
            end
            MODE_RUNNING: begin
                // only reached without restart, so the slew sees the live speed
                n_speed = w_slew;
                w_audio = 1'b1;
            end
            default: begin
                w_sound_off   = 1'b1;
                w_start_sound = 1'b1;
                n_speed       = '0;
                n_thr         = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_OFF;
            r_thr       <= '0;
            r_speed     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_thr       <= n_thr;
                r_speed     <= n_speed;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_fire) begin
            r_out_item.engine_state <= n_mode;
            r_out_item.rpm          <= n_speed;
            r_out_item.throttle     <= n_thr;
            r_out_item.start_sound  <= w_start_sound;
            r_out_item.sound_off    <= w_sound_off;
            r_out_item.audio_update <= w_audio;
        end
    end

endmodule
